// ===== rtl/core/trie_insert_search_prefix_macros.svh =====
// Assertion macros used by the trie checker file.
`ifndef TRIE_INSERT_SEARCH_PREFIX_MACROS_SVH
`define TRIE_INSERT_SEARCH_PREFIX_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TISP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TISP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tisp_pkg.sv =====
// Package: shared types and constants of the trie block.
`timescale 1ns / 1ps

package tisp_pkg;

  localparam int NODE_COUNT_DEF    = 256;
  localparam int ALPHABET_SIZE_DEF = 26;

  localparam int LETTER_W  = 5;
  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_PREFIX = 2'd2
  } tisp_req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_RES
  } tisp_state_e;

  // Port enables of the node store.
  typedef struct packed {
    logic child_re;
    logic child_we;
    logic flag_re;
    logic flag_we;
  } tisp_mem_ctl_t;

endpackage

// ===== rtl/core/tisp_store.sv =====
// Node store: child-link memory, word-end memory and the clearing sweep after reset.
`timescale 1ns / 1ps

module tisp_store #(
  parameter int NODE_COUNT    = tisp_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = tisp_pkg::ALPHABET_SIZE_DEF,
  localparam int NODE_W       = $clog2(NODE_COUNT),
  localparam int ADDR_W       = $clog2(NODE_COUNT * ALPHABET_SIZE)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tisp_pkg::tisp_mem_ctl_t ctl_i,
  input  logic [ADDR_W-1:0]      child_raddr_i,
  input  logic [ADDR_W-1:0]      child_waddr_i,
  input  logic [NODE_W-1:0]      child_wdata_i,
  output logic [NODE_W-1:0]      child_rdata_o,
  input  logic [NODE_W-1:0]      flag_raddr_i,
  input  logic [NODE_W-1:0]      flag_waddr_i,
  output logic                   flag_rdata_o,
  output logic                   busy_o
);
  import tisp_pkg::*;

  localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;

  logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
  logic              flag_mem  [NODE_COUNT];

  logic [NODE_W-1:0] child_rdata_q;
  logic              flag_rdata_q;
  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_flag;

  // flag memory is shorter; only the low part of the sweep touches it
  assign clr_flag = ({1'b0, clr_addr_q} < (ADDR_W + 1)'(NODE_COUNT));

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == ADDR_W'(CHILD_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      child_mem[clr_addr_q] <= '0;
    end else if (ctl_i.child_we) begin
      child_mem[child_waddr_i] <= child_wdata_i;
    end
    if (ctl_i.child_re) begin
      child_rdata_q <= child_mem[child_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (clr_flag) begin
        flag_mem[clr_addr_q[NODE_W-1:0]] <= 1'b0;
      end
    end else if (ctl_i.flag_we) begin
      flag_mem[flag_waddr_i] <= 1'b1;
    end
    if (ctl_i.flag_re) begin
      flag_rdata_q <= flag_mem[flag_raddr_i];
    end
  end

  assign child_rdata_o = child_rdata_q;
  assign flag_rdata_o  = flag_rdata_q;
  assign busy_o        = clr_busy_q;

endmodule

// ===== rtl/core/trie_insert_search_prefix.sv =====
// Top level: trie of lowercase words with insert, exact search and prefix test.
`timescale 1ns / 1ps

// Trie over words sent one letter per input transfer. tuser selects insert,
// search or prefix; tdata carries the letter, a has-letter bit (clear for the
// empty word) and a first-letter bit that restarts the walk at the root; tlast
// marks the final letter, and only that transfer yields one result transfer
// (found, pool_full). Nodes come from a pool of NODE_COUNT nodes; when it runs
// dry an insert stops and reports pool_full. Each input item passes through
// ST_IDLE, which issues the synchronous read of the child link, and ST_WALK,
// which resolves it and writes back a new node; tready is low in ST_WALK, so
// the next item is taken only after that. A last item then passes through
// ST_FIN, which reads the word-end memory, and ST_RES, which updates it and
// registers the result. After reset the block sweeps the link and word-end
// memories to zero before tready rises. A result waiting at the output does
// not hold up new input until the next result is due.

module trie_insert_search_prefix #(
  parameter int NODE_COUNT    = tisp_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = tisp_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [4:0] letter, [5] has_letter, [6] first_item, [7] zero
  input  logic [tisp_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [tisp_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  // last_item
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] found, [1] pool_full, [7:2] zero
  output logic [tisp_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import tisp_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int ADDR_W = $clog2(NODE_COUNT * ALPHABET_SIZE);
  localparam int FREE_W = NODE_W + 1;
  localparam logic [8:0] ALPHA_LIM = 9'(ALPHABET_SIZE);
  localparam logic [FREE_W-1:0] FREE_LIM = FREE_W'(NODE_COUNT);

  tisp_state_e state_q, state_d;

  // per-word walk state
  logic [NODE_W-1:0] node_q, node_d;
  logic [FREE_W-1:0] free_q, free_d;
  logic              missing_q, missing_d;
  logic              failed_q, failed_d;

  // item held across its cycles
  tisp_req_e         req_q, req_d;
  logic              last_q, last_d;
  logic              walk_q, walk_d;
  logic [ADDR_W-1:0] slot_q, slot_d;

  // result register
  logic out_valid_q, out_valid_d;
  logic out_found_q, out_found_d;
  logic out_full_q, out_full_d;

  // input fields
  logic [LETTER_W-1:0] in_letter;
  logic                in_has_letter;
  logic                in_first;

  // accept-cycle values
  logic [NODE_W-1:0] node_eff;
  logic              missing_eff;
  logic              failed_eff;
  logic              in_range;
  logic              can_walk;
  logic [ADDR_W-1:0] slot_addr;
  logic              out_free;

  // store interface
  tisp_mem_ctl_t     mem_ctl;
  logic [ADDR_W-1:0] child_waddr;
  logic [NODE_W-1:0] child_wdata;
  logic [NODE_W-1:0] child_rdata;
  logic              flag_rdata;
  logic              store_busy;

  assign in_letter     = s_axis_tdata_i[LETTER_W-1:0];
  assign in_has_letter = s_axis_tdata_i[LETTER_W];
  assign in_first      = s_axis_tdata_i[LETTER_W+1];

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // first letter restarts from the root with clean flags
  assign node_eff    = in_first ? '0 : node_q;
  assign missing_eff = in_first ? 1'b0 : missing_q;
  assign failed_eff  = in_first ? 1'b0 : failed_q;
  assign in_range    = ({4'b0000, in_letter} < ALPHA_LIM);
  assign can_walk    = in_has_letter && !missing_eff && !failed_eff;
  assign slot_addr   = ADDR_W'(node_eff) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(in_letter);
  assign out_free    = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    free_d      = free_q;
    missing_d   = missing_q;
    failed_d    = failed_q;
    req_d       = req_q;
    last_d      = last_q;
    walk_d      = walk_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    mem_ctl     = '0;
    child_waddr = slot_q;
    child_wdata = free_q[NODE_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        if (!store_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d     = tisp_req_e'(s_axis_tuser_i);
          last_d    = s_axis_tlast_i;
          node_d    = node_eff;
          failed_d  = failed_eff;
          // out-of-range letter leaves the stored paths
          missing_d = missing_eff || (can_walk && !in_range);
          walk_d    = can_walk && in_range;
          slot_d    = slot_addr;
          mem_ctl.child_re = can_walk && in_range;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_q) begin
          if (child_rdata != '0) begin
            node_d = child_rdata;
          end else if (req_q == REQ_INSERT) begin
            if (free_q < FREE_LIM) begin
              mem_ctl.child_we = 1'b1;
              node_d = free_q[NODE_W-1:0];
              free_d = free_q + FREE_W'(1);
            end else begin
              failed_d = 1'b1;
            end
          end else begin
            missing_d = 1'b1;
          end
        end
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        mem_ctl.flag_re = 1'b1;
        state_d = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_full_d  = 1'b0;
          if (req_q == REQ_INSERT) begin
            out_full_d  = failed_q;
            out_found_d = !failed_q && !missing_q;
            mem_ctl.flag_we = !failed_q && !missing_q;
          end else if (req_q == REQ_SEARCH) begin
            out_found_d = !missing_q && flag_rdata;
          end else begin
            out_found_d = !missing_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      node_q      <= '0;
      free_q      <= FREE_W'(1);
      missing_q   <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      free_q      <= free_d;
      missing_q   <= missing_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    last_q      <= last_d;
    walk_q      <= walk_d;
    slot_q      <= slot_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
  end

  tisp_store #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mem_ctl),
    .child_raddr_i(slot_addr),
    .child_waddr_i(child_waddr),
    .child_wdata_i(child_wdata),
    .child_rdata_o(child_rdata),
    .flag_raddr_i (node_q),
    .flag_waddr_i (node_q),
    .flag_rdata_o (flag_rdata),
    .busy_o       (store_busy)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - 2)'(0), out_full_q, out_found_q};

endmodule

// ===== rtl/core/tisp_checker.sv =====
// Port checker for the trie block, bound to the top level.
`timescale 1ns / 1ps
`include "trie_insert_search_prefix_macros.svh"

module tisp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tvalid_i,
  input logic                           s_tready_i,
  input logic                           m_tvalid_i,
  input logic                           m_tready_i,
  input logic [tisp_pkg::M_TDATA_W-1:0] m_tdata_i
);
  import tisp_pkg::*;

  // stalled result holds
  `TISP_ASSERT_NXT(a_out_hold, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i), "result changed while stalled")

  // an insert that ran out of nodes never reports the word stored
  `TISP_ASSERT_IMP(a_full_excl, m_tvalid_i, !(m_tdata_i[0] && m_tdata_i[1]), "found and pool_full both set")

  // each item occupies the link memory for its lookup cycle
  `TISP_ASSERT_NXT(a_item_busy, s_tvalid_i && s_tready_i, !s_tready_i, "input taken during lookup")

  // a new result is only loaded from the result stage, never while idle
  `TISP_ASSERT_IMP(a_res_stage, $rose(m_tvalid_i), $past(!s_tready_i), "result appeared while idle")

endmodule

bind trie_insert_search_prefix tisp_checker u_tisp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tvalid_i(s_axis_tvalid_i),
  .s_tready_i(s_axis_tready_o),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o)
);

// ===== sim/trie_insert_search_prefix_test.sv =====
// Testbench: trie insert, exact search and prefix test against a shadow trie.
`timescale 1ns / 1ps

// Words go in one letter per transfer. A shadow copy of the node pool walks
// each accepted transfer and queues the answer due on a last letter. Every
// result transfer is checked against the oldest queued answer. A directed
// table comes first: empty words, extreme letters, out-of-range letters,
// request code three, missing first marks and mixed request types. Then
// random words follow, mostly over a narrow alphabet so that paths share
// nodes and the pool runs dry partway through the run.

module trie_insert_search_prefix_test;
  import tisp_pkg::*;

  localparam int NODES       = NODE_COUNT_DEF;
  localparam int ALPHA       = ALPHABET_SIZE_DEF;
  localparam int ITEM_TARGET = 1300;
  localparam int IDLE_LIMIT  = 20000;  // covers the link-memory clear after reset
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REQ_RESERVED = 2'd3;  // decoded as a prefix test

  typedef struct packed {
    logic [1:0] req;
    logic [4:0] letter;
    logic       has;
    logic       first;
    logic       last;
  } letter_item_t;

  typedef struct packed {
    logic found;
    logic full;
  } answer_t;

  typedef struct packed {
    letter_item_t item;
    logic         typed;   // answer below is taken instead of the shadow trie
    answer_t      want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  trie_insert_search_prefix DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow trie
  int unsigned link_mem [NODES*ALPHA];
  bit          end_mark [NODES];
  int unsigned walk_node;
  int unsigned free_node;
  bit          off_path;
  bit          out_of_nodes;

  answer_t answers_q [$];

  int n_items, n_words, n_results, n_found, n_full, n_errors, burst_left;

  dir_row_t dir_table [DIR_ROWS] = '{
    // empty word right after reset: root is no word end yet, but is a prefix
    '{'{REQ_SEARCH,   5'd0,  1'b0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{REQ_PREFIX,   5'd0,  1'b0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{REQ_INSERT,   5'd0,  1'b0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{REQ_SEARCH,   5'd0,  1'b0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    // single letters at both ends of the alphabet
    '{'{REQ_INSERT,   5'd25, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{REQ_SEARCH,   5'd0,  1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{REQ_PREFIX,   5'd25, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    // "ab", then "a" is a path but not a word
    '{'{REQ_INSERT,   5'd0,  1'b1, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_INSERT,   5'd1,  1'b1, 1'b0, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{REQ_SEARCH,   5'd0,  1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    // request code three behaves as a prefix test
    '{'{REQ_RESERVED, 5'd0,  1'b1, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_RESERVED, 5'd1,  1'b1, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    // letters past z store nothing and are never found
    '{'{REQ_INSERT,   5'd31, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{REQ_SEARCH,   5'd26, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    // no first mark: walk carries on from where the last word stopped
    '{'{REQ_SEARCH,   5'd1,  1'b1, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    // request type changes inside a word
    '{'{REQ_INSERT,   5'd0,  1'b1, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_SEARCH,   5'd2,  1'b1, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_INSERT,   5'd3,  1'b1, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    // letterless items between letters only move the marks
    '{'{REQ_PREFIX,   5'd0,  1'b0, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_PREFIX,   5'd0,  1'b1, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_PREFIX,   5'd0,  1'b0, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_INSERT,   5'd31, 1'b0, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{REQ_INSERT,   5'd2,  1'b1, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}}
  };

  // Walk one accepted letter through the shadow trie; answer on a last item.
  task automatic walk_shadow(input letter_item_t it, output bit answered,
                             output answer_t ans);
    int unsigned slot;
    answered = 1'b0;
    ans      = '0;
    if (it.first) begin
      walk_node    = 0;
      off_path     = 1'b0;
      out_of_nodes = 1'b0;
    end
    if (it.has && !off_path && !out_of_nodes) begin
      if (it.letter >= ALPHA) begin
        off_path = 1'b1;
      end else begin
        slot = walk_node * ALPHA + it.letter;
        if (link_mem[slot] != 0) begin
          walk_node = link_mem[slot];
        end else if (it.req != REQ_INSERT) begin
          off_path = 1'b1;
        end else if (free_node < NODES) begin
          link_mem[slot] = free_node;
          walk_node      = free_node;
          free_node++;
        end else begin
          out_of_nodes = 1'b1;
        end
      end
    end
    if (it.last) begin
      answered = 1'b1;
      if (it.req == REQ_INSERT) begin
        if (out_of_nodes) begin
          ans.full = 1'b1;
        end else if (!off_path) begin
          end_mark[walk_node] = 1'b1;
          ans.found = 1'b1;
        end
      end else if (it.req == REQ_SEARCH) begin
        ans.found = !off_path && end_mark[walk_node];
      end else begin
        ans.found = !off_path;
      end
    end
  endtask

  // Offer one letter; bursts of back-to-back transfers with random gaps between.
  task automatic send_letter(input letter_item_t it, input bit typed, input answer_t want);
    int      gap;
    bit      answered;
    answer_t ans;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, it.first, it.has, it.letter};
    s_tuser  <= it.req;
    s_tlast  <= it.last;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    n_items++;
    walk_shadow(it, answered, ans);
    if (answered) answers_q.push_back(typed ? want : ans);
  endtask

  // Random word: mostly well formed over a narrow alphabet, some noise.
  task automatic send_random_word();
    int           len, lim, pick;
    bit           drop_first, drop_last;
    logic [1:0]   wreq;
    letter_item_t it;
    pick = $urandom_range(0, 99);
    wreq = (pick < 40) ? REQ_INSERT : (pick < 70) ? REQ_SEARCH :
           (pick < 95) ? REQ_PREFIX : REQ_RESERVED;
    n_words++;
    if ($urandom_range(0, 99) < 4) begin
      it = '{wreq, 5'($urandom_range(0, 31)), 1'b0, 1'b1, 1'b1};
      send_letter(it, 1'b0, '0);
    end else begin
      len        = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
      lim        = ($urandom_range(0, 3) == 0) ? ALPHA - 1 : 3;
      drop_first = $urandom_range(0, 99) < 6;
      drop_last  = $urandom_range(0, 99) < 5;
      for (int k = 0; k < len; k++) begin
        it.req    = ($urandom_range(0, 99) < 5) ? 2'($urandom_range(0, 3)) : wreq;
        it.letter = ($urandom_range(0, 99) < 2) ? 5'($urandom_range(ALPHA, 31))
                                                : 5'($urandom_range(0, lim));
        it.has    = $urandom_range(0, 99) >= 4;
        it.first  = ((k == 0) && !drop_first) || ($urandom_range(0, 99) < 2);
        it.last   = (k == len - 1) && !drop_last;
        send_letter(it, 1'b0, '0);
      end
    end
  endtask

  // Result side: a rotating choice of tready patterns, plus long hold-offs that
  // back the block up into its input.
  int rx_cycle, hold_left, holds_done;
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_left == 0 && ((holds_done == 0 && n_items >= 400) ||
                           (holds_done == 1 && n_items >= 1000))) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (rx_cycle % 4) == 0;
        default: m_tready <= $urandom_range(0, 4) != 0;
      endcase
    end
  end

  task automatic flag_mismatch(input string what, input answer_t want, input answer_t got);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t: %s: expected found=%0b pool_full=%0b, got found=%0b pool_full=%0b",
               $realtime, what, want.found, want.full, got.found, got.full);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    answer_t want, got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{m_tdata[0], m_tdata[1]};
      n_results++;
      if (got.found) n_found++;
      if (got.full) n_full++;
      if (answers_q.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = answers_q.pop_front();
        if (got.found !== want.found || got.full !== want.full)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: consecutive cycles without any transfer on either side.
  int idle_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (link_mem[i]) link_mem[i] = 0;
    foreach (end_mark[i]) end_mark[i] = 1'b0;
    walk_node    = 0;
    free_node    = 1;
    off_path     = 1'b0;
    out_of_nodes = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[r]) begin
      if (dir_table[r].item.first) n_words++;
      send_letter(dir_table[r].item, dir_table[r].typed, dir_table[r].want);
    end
    while (n_items < ITEM_TARGET) send_random_word();
    @(negedge clk_i);
    s_tvalid <= 1'b0;

    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d letter transfers in %0d words, %0d results (%0d found, %0d pool full)",
             n_items, n_words, n_results, n_found, n_full);
    $display("%0d of %0d pool nodes in use, %0d mismatches", free_node, NODES, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
